>>> hdl/patstore_pkg.sv
// Shared constants and operation codes for the parent array tree store.
`default_nettype none

package patstore_pkg;

  localparam int unsigned MaxNodesDef  = 64;
  localparam int unsigned LabelBitsDef = 16;

  typedef enum logic [3:0] {
    OP_ROOT    = 4'd0,
    OP_ADD     = 4'd1,
    OP_DELETE  = 4'd2,
    OP_GETROOT = 4'd3,
    OP_PARENT  = 4'd4,
    OP_CHILD   = 4'd5,
    OP_SIBLING = 4'd6,
    OP_RELABEL = 4'd7,
    OP_COUNT   = 4'd8
  } opcode_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

endpackage

`default_nettype wire

>>> hdl/patstore_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module patstore_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/parent_array_tree_store.sv
// Top level of the parent array tree store: sequencer around label and link memories.
//
// An ordered tree is kept as a parent array of up to MAX_NODES entries. Each
// item on the slave stream carries one operation: put root, add child, delete,
// get root, parent, leftmost child, right sibling, relabel or count. Each item
// gives exactly one result item on the master stream with a status, a label
// and the node count after the operation.
// Only one item is worked on at a time. Label lookups walk the label memory
// one entry per cycle for add child, relabel, delete, parent and right
// sibling; parent and right sibling then read the link memory and the label
// of the parent. Delete compacts the store one entry per cycle after
// its lookup. Leftmost child and right sibling walk the link memory and then
// the label memory through a two-stage pipeline, one entry per cycle. Each
// memory has a single read port.
// Reset empties the store at once; no clearing pass is needed.
// The result sits in an output register, so a stalled receiver does not hold
// up the next item: it is accepted and worked on, and only its result waits
// until the previous one has been taken.
`default_nettype none

module parent_array_tree_store
  import patstore_pkg::*;
#(
  parameter int unsigned MAX_NODES  = MaxNodesDef,
  parameter int unsigned LABEL_BITS = LabelBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // key_label [15:0], value_label [31:16]
  input  wire logic [31:0] s_axis_tdata,
  // opcode [3:0]
  input  wire logic [3:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_label [15:0], node_count [22:16], zero [23]
  output      logic [23:0] m_axis_tdata,
  // status [1:0]
  output      logic [1:0]  m_axis_tuser
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned LW = LABEL_BITS;

  typedef logic [LW-1:0] label_t;
  typedef struct packed {
    logic          hp;
    logic [IW-1:0] par;
  } link_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_SHIFT,
    S_LINK_RD,
    S_PAR_RD,
    S_SCAN,
    S_RD_LABEL,
    S_RESP
  } state_e;

  state_e        state_q, state_d;
  logic [3:0]    op_q, op_d;
  label_t        key_q, key_d;
  label_t        val_q, val_d;
  label_t        target_q, target_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] k_q, k_d;
  logic          s1_vld_q, s1_vld_d;
  logic [IW-1:0] s1_idx_q, s1_idx_d;
  logic          s2_vld_q, s2_vld_d;
  logic [IW-1:0] s2_idx_q, s2_idx_d;
  logic          s2_hp_q, s2_hp_d;
  logic [1:0]    status_q, status_d;
  label_t        res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [15:0]   out_res_q, out_res_d;
  logic [6:0]    out_count_q, out_count_d;

  logic          label_we;
  logic [IW-1:0] label_waddr;
  label_t        label_wdata;
  logic [IW-1:0] label_raddr;
  label_t        label_rdata;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  link_t         link_wdata;
  logic [IW-1:0] link_raddr;
  link_t         link_rdata;
  link_t         link_renum;
  logic          s_accept;
  logic          full;
  logic          s1_last;
  logic          s2_last;

  patstore_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_NODES)
  ) u_label_ram (
    .clk_i  (clk_i),
    .we_i   (label_we),
    .waddr_i(label_waddr),
    .wdata_i(label_wdata),
    .raddr_i(label_raddr),
    .rdata_o(label_rdata)
  );

  patstore_ram #(
    .WIDTH(IW + 1),
    .DEPTH(MAX_NODES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign full          = (count_q >= CW'(MAX_NODES));
  assign s1_last       = (CW'(s1_idx_q) == count_q - CW'(1));
  assign s2_last       = (CW'(s2_idx_q) == count_q - CW'(1));

  always_comb begin
    link_renum = link_rdata;
    if (link_rdata.hp) begin
      if (link_rdata.par == k_q) begin
        link_renum.hp = 1'b0;
      end else if (link_rdata.par > k_q) begin
        link_renum.par = link_rdata.par - IW'(1);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    target_d     = target_q;
    count_d      = count_q;
    idx_d        = idx_q;
    k_d          = k_q;
    s1_vld_d     = 1'b0;
    s1_idx_d     = s1_idx_q;
    s2_vld_d     = 1'b0;
    s2_idx_d     = s2_idx_q;
    s2_hp_d      = s2_hp_q;
    status_d     = status_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_res_d    = out_res_q;
    out_count_d  = out_count_q;
    label_we     = 1'b0;
    label_waddr  = count_q[IW-1:0];
    label_wdata  = val_q;
    label_raddr  = idx_q[IW-1:0];
    link_we      = 1'b0;
    link_waddr   = count_q[IW-1:0];
    link_wdata   = '0;
    link_raddr   = idx_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          op_d    = s_axis_tuser;
          key_d   = LW'($signed(s_axis_tdata[15:0]));
          val_d   = LW'($signed(s_axis_tdata[31:16]));
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = STAT_OK;
        res_d    = '0;
        idx_d    = '0;
        state_d  = S_RESP;
        case (op_q)
          OP_ROOT: begin
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              label_we = 1'b1;
              link_we  = 1'b1;
              count_d  = count_q + CW'(1);
            end
          end
          OP_ADD, OP_DELETE, OP_PARENT, OP_SIBLING, OP_RELABEL: begin
            if (op_q == OP_ADD && full) begin
              status_d = STAT_FULL;
            end else if (count_q == '0) begin
              status_d = STAT_MISS;
            end else begin
              state_d = S_FIND;
            end
          end
          OP_GETROOT: begin
            if (count_q == '0) begin
              status_d = STAT_MISS;
            end else begin
              label_raddr = '0;
              state_d     = S_RD_LABEL;
            end
          end
          OP_CHILD: begin
            target_d = key_q;
            if (count_q == '0) begin
              status_d = STAT_MISS;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_COUNT: begin
            status_d = STAT_OK;
          end
          default: begin
            status_d = STAT_MISS;
          end
        endcase
      end

      S_FIND: begin
        if (idx_q < count_q) begin
          label_raddr = idx_q[IW-1:0];
          idx_d       = idx_q + CW'(1);
          s1_vld_d    = 1'b1;
          s1_idx_d    = idx_q[IW-1:0];
        end
        if (s1_vld_q && label_rdata == key_q) begin
          k_d      = s1_idx_q;
          s1_vld_d = 1'b0;
          state_d  = S_RESP;
          case (op_q)
            OP_ADD: begin
              label_we        = 1'b1;
              link_we         = 1'b1;
              link_wdata.hp   = 1'b1;
              link_wdata.par  = s1_idx_q;
              count_d         = count_q + CW'(1);
            end
            OP_RELABEL: begin
              label_we    = 1'b1;
              label_waddr = s1_idx_q;
            end
            OP_DELETE: begin
              if (s1_last) begin
                count_d = count_q - CW'(1);
              end else begin
                idx_d   = CW'(s1_idx_q) + CW'(1);
                state_d = S_SHIFT;
              end
            end
            OP_PARENT, OP_SIBLING: begin
              link_raddr = s1_idx_q;
              state_d    = S_LINK_RD;
            end
            default: begin
              status_d = STAT_MISS;
            end
          endcase
        end else if (s1_vld_q && s1_last) begin
          status_d = STAT_MISS;
          s1_vld_d = 1'b0;
          state_d  = S_RESP;
        end
      end

      S_SHIFT: begin
        if (idx_q < count_q) begin
          label_raddr = idx_q[IW-1:0];
          link_raddr  = idx_q[IW-1:0];
          idx_d       = idx_q + CW'(1);
          s1_vld_d    = 1'b1;
          s1_idx_d    = idx_q[IW-1:0];
        end
        if (s1_vld_q) begin
          label_we    = 1'b1;
          label_waddr = s1_idx_q - IW'(1);
          label_wdata = label_rdata;
          link_we     = 1'b1;
          link_waddr  = s1_idx_q - IW'(1);
          link_wdata  = link_renum;
          if (s1_last) begin
            count_d  = count_q - CW'(1);
            s1_vld_d = 1'b0;
            state_d  = S_RESP;
          end
        end
      end

      S_LINK_RD: begin
        if (!link_rdata.hp) begin
          status_d = STAT_MISS;
          state_d  = S_RESP;
        end else begin
          label_raddr = link_rdata.par;
          state_d     = S_PAR_RD;
        end
      end

      S_PAR_RD: begin
        if (op_q == OP_PARENT) begin
          res_d   = label_rdata;
          state_d = S_RESP;
        end else begin
          target_d = label_rdata;
          if (CW'(k_q) + CW'(1) >= count_q) begin
            status_d = STAT_MISS;
            state_d  = S_RESP;
          end else begin
            idx_d   = CW'(k_q) + CW'(1);
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx_q < count_q) begin
          link_raddr = idx_q[IW-1:0];
          idx_d      = idx_q + CW'(1);
          s1_vld_d   = 1'b1;
          s1_idx_d   = idx_q[IW-1:0];
        end
        if (s1_vld_q) begin
          label_raddr = link_rdata.par;
          s2_vld_d    = 1'b1;
          s2_idx_d    = s1_idx_q;
          s2_hp_d     = link_rdata.hp;
        end
        if (s2_vld_q) begin
          if (s2_hp_q && label_rdata == target_q) begin
            label_raddr = s2_idx_q;
            s1_vld_d    = 1'b0;
            s2_vld_d    = 1'b0;
            state_d     = S_RD_LABEL;
          end else if (s2_last) begin
            status_d = STAT_MISS;
            s1_vld_d = 1'b0;
            s2_vld_d = 1'b0;
            state_d  = S_RESP;
          end
        end
      end

      S_RD_LABEL: begin
        res_d    = label_rdata;
        status_d = STAT_OK;
        state_d  = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_res_d    = 16'(res_q);
          out_count_d  = 7'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      key_q        <= '0;
      val_q        <= '0;
      target_q     <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      s1_vld_q     <= 1'b0;
      s1_idx_q     <= '0;
      s2_vld_q     <= 1'b0;
      s2_idx_q     <= '0;
      s2_hp_q      <= 1'b0;
      status_q     <= STAT_OK;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_res_q    <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      val_q        <= val_d;
      target_q     <= target_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      k_q          <= k_d;
      s1_vld_q     <= s1_vld_d;
      s1_idx_q     <= s1_idx_d;
      s2_vld_q     <= s2_vld_d;
      s2_idx_q     <= s2_idx_d;
      s2_hp_q      <= s2_hp_d;
      status_q     <= status_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_res_q    <= out_res_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_res_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire
